// File: rtl/core/adsr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adsr_pkg
// shared types and codes for the multi-voice envelope generator
// ----------------------------------------------------------------------------
package adsr_pkg;

  localparam logic [1:0] ACT_NOTE_ON  = 2'd0;
  localparam logic [1:0] ACT_NOTE_OFF = 2'd1;
  localparam logic [1:0] ACT_UPDATE   = 2'd2;

  localparam logic [1:0] MODE_GATED = 2'd0;
  localparam logic [1:0] MODE_DRUM  = 2'd2;

  localparam logic [2:0] STG_ATTACK  = 3'd0;
  localparam logic [2:0] STG_DECAY   = 3'd1;
  localparam logic [2:0] STG_SUSTAIN = 3'd2;
  localparam logic [2:0] STG_RELEASE = 3'd3;
  localparam logic [2:0] STG_DONE    = 3'd4;

  localparam logic [1:0] REG_ATTACK  = 2'd0;
  localparam logic [1:0] REG_DECAY   = 2'd1;
  localparam logic [1:0] REG_SUSTAIN = 2'd2;
  localparam logic [1:0] REG_RELEASE = 2'd3;

  localparam longint unsigned CURVE_STEP_Q16 = 64'd64520;
  localparam longint unsigned ONE_Q16        = 64'd65536;

  // per-voice record held in the state memory
  typedef struct packed {
    logic [2:0]  stage;
    logic [31:0] start_ms;
    logic [7:0]  lbr;
    logic [6:0]  vel;
    logic [1:0]  mode;
    logic [15:0] drum_a;
    logic [15:0] drum_r;
  } voice_rec_t;

endpackage

// File: rtl/core/adsr_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adsr_ram
// generic single-port-write ram with registered read
// ----------------------------------------------------------------------------
module adsr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                                clk,
  input  logic                                we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                    wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                    rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/core/adsr_envelope_voices.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adsr_envelope_voices
// multi-voice exponential attack/decay/sustain/release envelope generator
// ----------------------------------------------------------------------------
// One word at a time. Note on and note off give no result and leave busy low.
// An update gives one result strobe on out_valid: registered at acceptance
// for an idle or unknown voice, from S_READ for a gated voice, via S_READ and
// S_SCALE for sustain or done, via S_READ, S_MUL, S_ROM, S_LVL and S_SCALE
// when the curve index saturates, and with S_DIV after S_MUL when the curve
// index needs the bit-serial divider, which takes one quotient bit per cycle.
// busy drops in the strobe cycle, so the next word is taken at the edge that
// ends it. Voice state lives in a registered-read ram, read on acceptance and
// written back in S_SCALE as the result goes out. The result cannot be stalled.
// ----------------------------------------------------------------------------
module adsr_envelope_voices
  import adsr_pkg::*;
#(
  parameter int VOICE_COUNT   = 8,
  parameter int CURVE_ENTRIES = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_action,
  input  logic [2:0]  in_voice_index,
  input  logic [31:0] in_now_ms,
  input  logic [6:0]  in_velocity,
  input  logic [1:0]  in_voice_kind,
  input  logic [15:0] in_hit_attack_ms,
  input  logic [15:0] in_hit_release_ms,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata,
  output logic        out_valid,
  output logic [2:0]  out_voice_out,
  output logic [7:0]  out_level,
  output logic        out_voice_on,
  output logic [2:0]  out_envelope_stage
);

  localparam int VW = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
  localparam int IW = $clog2(CURVE_ENTRIES);
  localparam int PW = 16 + IW;
  localparam int RW = $bits(voice_rec_t);
  localparam logic [IW-1:0] LAST_IDX = IW'(CURVE_ENTRIES - 1);

  typedef logic [7:0] curve_tab_t [CURVE_ENTRIES];

  function automatic longint unsigned curve_floor();
    longint unsigned e;
    e = ONE_Q16;
    for (int x = 0; x < CURVE_ENTRIES; x++) begin
      e = (e * CURVE_STEP_Q16) >> 16;
    end
    return e;
  endfunction

  localparam longint unsigned CURVE_DEN = ONE_Q16 - curve_floor();

  function automatic curve_tab_t build_curve();
    longint unsigned e;
    longint unsigned f;
    longint unsigned v [CURVE_ENTRIES+1];
    curve_tab_t      t;
    e = ONE_Q16;
    for (int x = 0; x <= CURVE_ENTRIES; x++) begin
      v[x] = e;
      e = (e * CURVE_STEP_Q16) >> 16;
    end
    f = v[CURVE_ENTRIES];
    for (int x = 0; x < CURVE_ENTRIES; x++) begin
      t[x] = 8'((v[x] - f) * 255 / CURVE_DEN);
    end
    return t;
  endfunction

  localparam curve_tab_t CURVE = build_curve();

  typedef enum logic [2:0] {
    S_IDLE, S_READ, S_MUL, S_DIV, S_ROM, S_LVL, S_SCALE
  } state_t;

  state_t           state_r;
  logic [15:0]      attack_r, decay_r, release_r;
  logic [7:0]       sustain_r;
  logic [VOICE_COUNT-1:0] active_r, key_r;
  logic [VW-1:0]    addr_r;
  logic [2:0]       voice_r;
  logic [31:0]      now_r;
  voice_rec_t       rec_r;
  logic [2:0]       st_r;
  logic             nxt_r, kill_r;
  logic [7:0]       lbr_r;
  logic [31:0]      dt_r;
  logic [15:0]      dur_r;
  logic [15:0]      rem_r;
  logic [IW-1:0]    low_r, idx_r;
  logic [$clog2(IW+1)-1:0] cnt_r;
  logic [7:0]       c_r, env_r;

  logic [6:0]       vi_ext;
  logic [VW-1:0]    in_addr;
  logic             in_ok, accept;
  logic             ram_we;
  logic [VW-1:0]    ram_waddr;
  voice_rec_t       ram_wdata, rd;
  logic [RW-1:0]    ram_rdata;

  // read-stage decode
  logic [31:0]      dt;
  logic [15:0]      a_dur, d_dur, r_dur, dur_sel;
  logic [2:0]       st;
  logic             nxt, kill, drum;
  logic [7:0]       lbr;
  logic [PW-1:0]    prod;
  logic [16:0]      trial;
  logic [16:0]      diff;
  logic [15:0]      lvl_decay;
  logic [15:0]      lvl_rel;
  logic [14:0]      scaled;

  assign vi_ext  = 7'(in_voice_index);
  assign in_addr = vi_ext[VW-1:0];
  assign in_ok   = (32'(in_voice_index) < 32'(VOICE_COUNT));
  assign accept  = start && (state_r == S_IDLE);
  assign busy    = (state_r != S_IDLE);
  assign rd      = voice_rec_t'(ram_rdata);

  always_comb begin
    drum  = (rd.mode == MODE_DRUM);
    a_dur = drum ? rd.drum_a : attack_r;
    d_dur = decay_r;
    r_dur = drum ? rd.drum_r : release_r;
    dt    = now_r - rd.start_ms;
    st    = rd.stage;
    nxt   = 1'b0;
    kill  = 1'b0;
    lbr   = rd.lbr;
    case (st)
      STG_ATTACK: begin
        if (dt > 32'(a_dur)) begin
          nxt = 1'b1;
          if (drum) begin
            st  = STG_SUSTAIN;
            lbr = 8'd255;
          end
        end
      end
      STG_DECAY: begin
        if (dt > 32'(d_dur)) nxt = 1'b1;
      end
      STG_RELEASE: begin
        if (dt > 32'(r_dur)) begin
          nxt  = 1'b1;
          kill = 1'b1;
        end
      end
      default: ;
    endcase
    if (st < STG_RELEASE && !key_r[addr_r]) begin
      st  = STG_SUSTAIN;
      nxt = 1'b1;
    end
    if (nxt) st = st + 3'd1;
    case (st)
      STG_ATTACK: dur_sel = a_dur;
      STG_DECAY:  dur_sel = d_dur;
      default:    dur_sel = r_dur;
    endcase
    if (dur_sel == 16'd0) dur_sel = 16'd1;
  end

  always_comb begin
    prod      = PW'(dt_r[15:0]) * PW'(CURVE_ENTRIES - 1);
    trial     = {rem_r, low_r[IW-1]};
    diff      = trial - 17'(dur_r);
    lvl_decay = 16'(8'd255 - sustain_r) * 16'(c_r);
    lvl_rel   = 16'(lbr_r) * 16'(c_r);
    scaled    = 15'(env_r) * 15'(rec_r.vel);
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = in_addr;
    ram_wdata = rec_r;
    if (accept && in_action == ACT_NOTE_ON && in_ok) begin
      ram_we          = 1'b1;
      ram_wdata.stage    = STG_ATTACK;
      ram_wdata.start_ms = in_now_ms;
      ram_wdata.lbr      = 8'd0;
      ram_wdata.vel      = in_velocity;
      ram_wdata.mode     = in_voice_kind;
      ram_wdata.drum_a   = in_hit_attack_ms;
      ram_wdata.drum_r   = in_hit_release_ms;
    end else if (state_r == S_SCALE) begin
      ram_we    = 1'b1;
      ram_waddr = addr_r;
      ram_wdata.stage = st_r;
      if (nxt_r) ram_wdata.start_ms = now_r;
      ram_wdata.lbr = (st_r < STG_RELEASE) ? env_r : lbr_r;
    end
  end

  adsr_ram #(
    .WIDTH (RW),
    .DEPTH (VOICE_COUNT)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (RW'(ram_wdata)),
    .raddr (in_addr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      attack_r  <= 16'd10;
      decay_r   <= 16'd100;
      sustain_r <= 8'd128;
      release_r <= 16'd100;
      active_r  <= '0;
      key_r     <= '0;
      out_valid <= 1'b0;
    end else begin
      out_valid <= 1'b0;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_ATTACK:  attack_r  <= cfg_wdata;
          REG_DECAY:   decay_r   <= cfg_wdata;
          REG_SUSTAIN: sustain_r <= cfg_wdata[7:0];
          REG_RELEASE: release_r <= cfg_wdata;
        endcase
      end
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            addr_r  <= in_addr;
            voice_r <= in_voice_index;
            now_r   <= in_now_ms;
            case (in_action)
              ACT_NOTE_ON: begin
                if (in_ok) begin
                  active_r[in_addr] <= 1'b1;
                  key_r[in_addr]    <= 1'b1;
                end
              end
              ACT_NOTE_OFF: begin
                if (in_ok) key_r[in_addr] <= 1'b0;
              end
              ACT_UPDATE: begin
                if (in_ok && active_r[in_addr]) begin
                  state_r <= S_READ;
                end else begin
                  out_valid          <= 1'b1;
                  out_voice_out      <= in_voice_index;
                  out_level          <= 8'd0;
                  out_voice_on       <= 1'b0;
                  out_envelope_stage <= STG_DONE;
                end
              end
              default: ;
            endcase
          end
        end
        S_READ: begin
          rec_r  <= rd;
          st_r   <= st;
          nxt_r  <= nxt;
          kill_r <= kill;
          lbr_r  <= lbr;
          dt_r   <= nxt ? 32'd0 : dt;
          dur_r  <= dur_sel;
          if (rd.mode == MODE_GATED) begin
            out_valid          <= 1'b1;
            out_voice_out      <= voice_r;
            out_level          <= key_r[addr_r] ? {rd.vel, 1'b0} : 8'd0;
            out_voice_on       <= key_r[addr_r];
            out_envelope_stage <= key_r[addr_r] ? rd.stage : STG_DONE;
            if (!key_r[addr_r]) active_r[addr_r] <= 1'b0;
            state_r <= S_IDLE;
          end else if (st == STG_SUSTAIN) begin
            env_r   <= sustain_r;
            state_r <= S_SCALE;
          end else if (st == STG_DONE) begin
            env_r   <= 8'd0;
            state_r <= S_SCALE;
          end else begin
            state_r <= S_MUL;
          end
        end
        S_MUL: begin
          if (dt_r >= 32'(dur_r)) begin
            idx_r   <= LAST_IDX;
            state_r <= S_ROM;
          end else begin
            rem_r   <= prod[PW-1:IW];
            low_r   <= prod[IW-1:0];
            idx_r   <= '0;
            cnt_r   <= '0;
            state_r <= S_DIV;
          end
        end
        S_DIV: begin
          if (!diff[16]) begin
            rem_r <= diff[15:0];
          end else begin
            rem_r <= trial[15:0];
          end
          idx_r <= {idx_r[IW-2:0], !diff[16]};
          low_r <= low_r << 1;
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == ($clog2(IW+1))'(IW - 1)) state_r <= S_ROM;
        end
        S_ROM: begin
          c_r     <= CURVE[idx_r];
          state_r <= S_LVL;
        end
        S_LVL: begin
          case (st_r)
            STG_ATTACK: env_r <= 8'd255 - c_r;
            STG_DECAY:  env_r <= lvl_decay[15:8] + sustain_r;
            default:    env_r <= lvl_rel[15:8];
          endcase
          state_r <= S_SCALE;
        end
        S_SCALE: begin
          out_valid          <= 1'b1;
          out_voice_out      <= voice_r;
          out_level          <= scaled[14:7];
          out_voice_on       <= !kill_r;
          out_envelope_stage <= kill_r ? STG_DONE : st_r;
          if (kill_r) active_r[addr_r] <= 1'b0;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_silent_off : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_voice_on |-> out_envelope_stage == STG_DONE)
    else $error("silent voice reported with a live stage");

  a_sounding : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_voice_on |-> out_envelope_stage != STG_DONE)
    else $error("sounding voice reported as done");

  a_strobe_src : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r == S_SCALE || state_r == S_READ || accept))
    else $error("result strobe without a word in flight");

  a_div_len : assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DIV |-> cnt_r < ($clog2(IW+1))'(IW))
    else $error("divider overran its step count");
`endif

endmodule
